FILE: rtl/core/mpt_pkg.sv
package mpt_pkg;

  localparam int unsigned MaxChannels = 7;
  localparam int unsigned DefaultChannels = 7;
  localparam int unsigned DataW = 32;
  localparam int unsigned AddrW = 10;
  localparam int unsigned FlagW = 11;
  localparam int unsigned CtrlW = 4;
  localparam int unsigned LatchW = 7;
  localparam int unsigned EdgeW = 6;

  // Register byte offsets.
  localparam logic [AddrW-1:0] AddrIr   = 10'h000;
  localparam logic [AddrW-1:0] AddrTcr  = 10'h004;
  localparam logic [AddrW-1:0] AddrTc   = 10'h008;
  localparam logic [AddrW-1:0] AddrPr   = 10'h00C;
  localparam logic [AddrW-1:0] AddrPc   = 10'h010;
  localparam logic [AddrW-1:0] AddrMcr  = 10'h014;
  localparam logic [AddrW-1:0] AddrMr0  = 10'h018;
  localparam logic [AddrW-1:0] AddrMr1  = 10'h01C;
  localparam logic [AddrW-1:0] AddrMr2  = 10'h020;
  localparam logic [AddrW-1:0] AddrMr3  = 10'h024;
  localparam logic [AddrW-1:0] AddrMr4  = 10'h040;
  localparam logic [AddrW-1:0] AddrMr5  = 10'h044;
  localparam logic [AddrW-1:0] AddrMr6  = 10'h048;
  localparam logic [AddrW-1:0] AddrPcr  = 10'h04C;
  localparam logic [AddrW-1:0] AddrLer  = 10'h050;
  localparam logic [AddrW-1:0] AddrCtcr = 10'h070;

  // Timer control bit positions.
  localparam int unsigned TcrEnable = 0;
  localparam int unsigned TcrReset  = 1;
  localparam int unsigned TcrPwm    = 3;
  localparam logic [CtrlW-1:0] TcrMask = 4'hB;

  localparam logic [FlagW-1:0]  IrqMask   = 11'h70F;
  localparam logic [LatchW-1:0] LatchMask = 7'h7F;

  typedef enum logic [1:0] {
    OpTick  = 2'd0,
    OpRead  = 2'd1,
    OpWrite = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]       operation;
    logic [AddrW-1:0] address;
    logic [DataW-1:0] write_data;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             irq_level;
    logic [EdgeW-1:0] falling_edges;
    logic             cycle_start;
  } result_t;

  typedef struct packed {
    logic       hit;
    logic [2:0] idx;
  } chan_sel_t;

  // Maps a byte offset onto a match register slot.
  function automatic chan_sel_t chan_decode(logic [AddrW-1:0] addr);
    chan_sel_t sel;
    sel = '{hit: 1'b1, idx: 3'd0};
    case (addr)
      AddrMr0: sel.idx = 3'd0;
      AddrMr1: sel.idx = 3'd1;
      AddrMr2: sel.idx = 3'd2;
      AddrMr3: sel.idx = 3'd3;
      AddrMr4: sel.idx = 3'd4;
      AddrMr5: sel.idx = 3'd5;
      AddrMr6: sel.idx = 3'd6;
      default: sel.hit = 1'b0;
    endcase
    return sel;
  endfunction

  // Channels 0..3 flag at bits 0..3, channels 4..6 at bits 8..10.
  function automatic logic [3:0] flag_index(logic [2:0] ch);
    logic [3:0] idx;
    idx = (ch <= 3'd3) ? {1'b0, ch} : ({1'b0, ch} + 4'd4);
    return idx;
  endfunction

endpackage

FILE: rtl/core/mpt_core.sv
module mpt_core #(
  parameter int unsigned MatchChannels = mpt_pkg::DefaultChannels
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  mpt_pkg::req_t    req_i,
  output mpt_pkg::result_t res_o
);

  localparam int unsigned ChW = $clog2(MatchChannels);
  localparam int unsigned DW = mpt_pkg::DataW;

  logic [mpt_pkg::FlagW-1:0]  flags_q, flags_d;
  logic [mpt_pkg::CtrlW-1:0]  tcr_q, tcr_d;
  logic [DW-1:0]              tc_q, tc_d;
  logic [DW-1:0]              pr_q, pr_d;
  logic [DW-1:0]              pc_q, pc_d;
  logic [DW-1:0]              mcr_q, mcr_d;
  logic [DW-1:0]              pcr_q, pcr_d;
  logic [mpt_pkg::LatchW-1:0] ler_q, ler_d;
  logic [DW-1:0]              ctcr_q, ctcr_d;
  logic [DW-1:0]              mr_q [MatchChannels];
  logic [DW-1:0]              mr_d [MatchChannels];
  logic [DW-1:0]              sh_q [MatchChannels];
  logic [DW-1:0]              sh_d [MatchChannels];

  mpt_pkg::chan_sel_t         sel;
  logic                       sel_ok;
  logic [DW-1:0]              tc_inc;
  logic [mpt_pkg::MaxChannels-1:0] hit;
  logic                       any_rst;
  logic                       rst0;
  mpt_pkg::result_t           res;

  assign sel    = mpt_pkg::chan_decode(req_i.address);
  assign sel_ok = sel.hit && (sel.idx < 3'(MatchChannels));
  assign tc_inc = tc_q + 32'd1;

  always_comb begin
    hit = '0;
    for (int i = 0; i < MatchChannels; i++) begin
      hit[i] = (tc_inc == mr_q[i]);
    end
  end

  always_comb begin
    flags_d = flags_q;
    tcr_d   = tcr_q;
    tc_d    = tc_q;
    pr_d    = pr_q;
    pc_d    = pc_q;
    mcr_d   = mcr_q;
    pcr_d   = pcr_q;
    ler_d   = ler_q;
    ctcr_d  = ctcr_q;
    mr_d    = mr_q;
    sh_d    = sh_q;
    any_rst = 1'b0;
    rst0    = 1'b0;
    res     = '0;

    case (mpt_pkg::op_e'(req_i.operation))
      mpt_pkg::OpTick: begin
        if (tcr_q[mpt_pkg::TcrEnable] && !tcr_q[mpt_pkg::TcrReset]) begin
          if (pc_q < pr_q) begin
            pc_d = pc_q + 32'd1;
          end else begin
            pc_d = '0;
            tc_d = tc_inc;
            for (int i = 0; i < MatchChannels; i++) begin
              if (hit[i]) begin
                if (mcr_q[3*i]) begin
                  flags_d[mpt_pkg::flag_index(3'(i))] = 1'b1;
                end
                if (mcr_q[3*i+1]) begin
                  any_rst = 1'b1;
                end
                if (mcr_q[3*i+2]) begin
                  tcr_d[mpt_pkg::TcrEnable] = 1'b0;
                end
              end
            end
            rst0 = hit[0] && mcr_q[1];
            for (int j = 0; j < mpt_pkg::EdgeW; j++) begin
              res.falling_edges[j] = hit[j+1] && pcr_q[9+j];
            end
            if (any_rst) begin
              tc_d = '0;
              pc_d = '0;
              if (tcr_q[mpt_pkg::TcrPwm]) begin
                for (int i = 0; i < MatchChannels; i++) begin
                  if (ler_q[i]) begin
                    mr_d[i] = sh_q[i];
                  end
                end
                ler_d = '0;
              end
              res.cycle_start = rst0;
            end
          end
        end
      end
      mpt_pkg::OpRead: begin
        case (req_i.address)
          mpt_pkg::AddrIr:   res.read_data = DW'(flags_q);
          mpt_pkg::AddrTcr:  res.read_data = DW'(tcr_q);
          mpt_pkg::AddrTc:   res.read_data = tcr_q[mpt_pkg::TcrReset] ? '0 : tc_q;
          mpt_pkg::AddrPr:   res.read_data = pr_q;
          mpt_pkg::AddrPc:   res.read_data = pc_q;
          mpt_pkg::AddrMcr:  res.read_data = mcr_q;
          mpt_pkg::AddrPcr:  res.read_data = pcr_q;
          mpt_pkg::AddrLer:  res.read_data = DW'(ler_q);
          mpt_pkg::AddrCtcr: res.read_data = ctcr_q;
          default: begin
            if (sel_ok) begin
              res.read_data = mr_q[sel.idx[ChW-1:0]];
            end
          end
        endcase
      end
      mpt_pkg::OpWrite: begin
        case (req_i.address)
          mpt_pkg::AddrIr: begin
            flags_d = flags_q & ~req_i.write_data[mpt_pkg::FlagW-1:0] & mpt_pkg::IrqMask;
          end
          mpt_pkg::AddrTcr: begin
            tcr_d = req_i.write_data[mpt_pkg::CtrlW-1:0] & mpt_pkg::TcrMask;
            if (tcr_d[mpt_pkg::TcrReset]) begin
              tc_d = '0;
              pc_d = '0;
            end else if (tcr_d[mpt_pkg::TcrPwm] != tcr_q[mpt_pkg::TcrPwm]) begin
              tc_d = DW'(tcr_d[mpt_pkg::TcrPwm]);
              pc_d = '0;
            end
          end
          mpt_pkg::AddrTc:   tc_d = req_i.write_data;
          mpt_pkg::AddrPr:   pr_d = req_i.write_data;
          mpt_pkg::AddrPc:   pc_d = req_i.write_data;
          mpt_pkg::AddrMcr:  mcr_d = req_i.write_data;
          mpt_pkg::AddrPcr:  pcr_d = req_i.write_data;
          mpt_pkg::AddrLer:  ler_d = req_i.write_data[mpt_pkg::LatchW-1:0] & mpt_pkg::LatchMask;
          mpt_pkg::AddrCtcr: ctcr_d = req_i.write_data;
          default: begin
            if (sel_ok) begin
              sh_d[sel.idx[ChW-1:0]] = req_i.write_data;
              if (!tcr_q[mpt_pkg::TcrPwm]) begin
                mr_d[sel.idx[ChW-1:0]] = req_i.write_data;
              end
            end
          end
        endcase
      end
      default: begin
      end
    endcase

    res.irq_level = |flags_d;
  end

  assign res_o = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      tcr_q   <= '0;
      tc_q    <= '0;
      pr_q    <= '0;
      pc_q    <= '0;
      mcr_q   <= '0;
      pcr_q   <= '0;
      ler_q   <= '0;
      ctcr_q  <= '0;
      for (int i = 0; i < MatchChannels; i++) begin
        mr_q[i] <= '0;
        sh_q[i] <= '0;
      end
    end else if (fire_i) begin
      flags_q <= flags_d;
      tcr_q   <= tcr_d;
      tc_q    <= tc_d;
      pr_q    <= pr_d;
      pc_q    <= pc_d;
      mcr_q   <= mcr_d;
      pcr_q   <= pcr_d;
      ler_q   <= ler_d;
      ctcr_q  <= ctcr_d;
      mr_q    <= mr_d;
      sh_q    <= sh_d;
    end
  end

endmodule

FILE: rtl/core/match_pwm_timer_registers.sv
// Channel | Direction | Handshake         | Payload
// in      | to block  | in_valid_i/stall  | operation_i, address_i, write_data_i
// out     | from block| out_valid_o/stall | read_data_o, irq_level_o,
//         |           |                   | falling_edges_o, cycle_start_o
//
// One item per cycle while the output is not held. An accepted transfer waits
// in the input register, is worked against the register file and lands in the
// result register, from which it can be taken when the output is not held.
// Reset clears the timer state and both stages at once; no warm-up is needed.
// A held output stalls the input only while the input register is also full.
module match_pwm_timer_registers #(
  parameter int unsigned MatchChannels = mpt_pkg::DefaultChannels
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   operation_i,
  input  logic [mpt_pkg::AddrW-1:0]    address_i,
  input  logic [mpt_pkg::DataW-1:0]    write_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mpt_pkg::DataW-1:0]    read_data_o,
  output logic                         irq_level_o,
  output logic [mpt_pkg::EdgeW-1:0]    falling_edges_o,
  output logic                         cycle_start_o
);

  logic             s1_valid_q, s1_valid_d;
  mpt_pkg::req_t    s1_req_q;
  logic             out_valid_q, out_valid_d;
  mpt_pkg::result_t out_res_q;
  mpt_pkg::result_t core_res;
  logic             out_load;
  logic             s1_fire;
  logic             in_fire;

  assign out_load    = !out_valid_q || !out_stall_i;
  assign s1_fire     = s1_valid_q && out_load;
  assign in_stall_o  = s1_valid_q && !out_load;
  assign in_fire     = in_valid_i && !in_stall_o;
  assign s1_valid_d  = in_fire || (s1_valid_q && !s1_fire);
  assign out_valid_d = s1_fire || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_req_q <= '{operation: operation_i, address: address_i, write_data: write_data_i};
    end
    if (s1_fire) begin
      out_res_q <= core_res;
    end
  end

  mpt_core #(
    .MatchChannels(MatchChannels)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (s1_fire),
    .req_i  (s1_req_q),
    .res_o  (core_res)
  );

  assign out_valid_o     = out_valid_q;
  assign read_data_o     = out_res_q.read_data;
  assign irq_level_o     = out_res_q.irq_level;
  assign falling_edges_o = out_res_q.falling_edges;
  assign cycle_start_o   = out_res_q.cycle_start;

endmodule

FILE: rtl/core/mpt_checker.sv
module mpt_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [mpt_pkg::DataW-1:0] read_data_o,
  input logic [mpt_pkg::EdgeW-1:0] falling_edges_o,
  input logic                      cycle_start_o
);

  // The input side only backs up behind a held result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // Tick results never carry read data.
  a_tick_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (cycle_start_o || (falling_edges_o != '0))) |-> (read_data_o == '0))
    else $error("tick result carries read data");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("held result dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> ($stable(read_data_o) && $stable(falling_edges_o)
                                      && $stable(cycle_start_o)))
    else $error("held result changed");

endmodule

bind match_pwm_timer_registers mpt_checker u_mpt_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .read_data_o     (read_data_o),
  .falling_edges_o (falling_edges_o),
  .cycle_start_o   (cycle_start_o)
);

FILE: sim/tb.sv
module tb;
  import mpt_pkg::*;

  localparam int unsigned NumMatch = DefaultChannels;
  localparam int QuietLimit = 2000;
  localparam logic [1:0] OpUnused = 2'd3;
  localparam logic [31:0] StopBits = 32'h0012_4924;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [1:0]        operation_i = OpTick;
  logic [AddrW-1:0]  address_i = '0;
  logic [DataW-1:0]  write_data_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [DataW-1:0]  read_data_o;
  logic              irq_level_o;
  logic [EdgeW-1:0]  falling_edges_o;
  logic              cycle_start_o;

  int send_gap_pct = 16;
  int stall_pct = 63;
  int items_sent = 0;

  match_pwm_timer_registers #(
    .MatchChannels(NumMatch)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .address_i      (address_i),
    .write_data_i   (write_data_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_data_o    (read_data_o),
    .irq_level_o    (irq_level_o),
    .falling_edges_o(falling_edges_o),
    .cycle_start_o  (cycle_start_o)
  );

  // Mirrors the timer register file and queues the outcome of every access.
  class timer_scoreboard;
    logic [FlagW-1:0]  irq_pending = '0;
    logic [CtrlW-1:0]  ctrl = '0;
    logic [31:0]       count = '0;
    logic [31:0]       prescale_max = '0;
    logic [31:0]       prescale_cnt = '0;
    logic [31:0]       match_ctl = '0;
    logic [31:0]       out_ctl = '0;
    logic [31:0]       count_mode = '0;
    logic [LatchW-1:0] latch_arm = '0;
    logic [31:0]       match_reg[MaxChannels];
    logic [31:0]       shadow_reg[MaxChannels];
    result_t           expected_results[$];
    int errors = 0;
    int checked = 0;
    int starts = 0;
    int edge_hits = 0;

    function new();
      foreach (match_reg[i]) begin
        match_reg[i] = '0;
        shadow_reg[i] = '0;
      end
    endfunction

    function int match_slot(logic [AddrW-1:0] addr);
      int slot;
      case (addr)
        AddrMr0: slot = 0;
        AddrMr1: slot = 1;
        AddrMr2: slot = 2;
        AddrMr3: slot = 3;
        AddrMr4: slot = 4;
        AddrMr5: slot = 5;
        AddrMr6: slot = 6;
        default: slot = -1;
      endcase
      if (slot >= int'(NumMatch)) slot = -1;
      return slot;
    endfunction

    function logic [31:0] register_value(logic [AddrW-1:0] addr);
      int slot;
      case (addr)
        AddrIr:   return 32'(irq_pending);
        AddrTcr:  return 32'(ctrl);
        AddrTc:   return ctrl[TcrReset] ? 32'd0 : count;
        AddrPr:   return prescale_max;
        AddrPc:   return prescale_cnt;
        AddrMcr:  return match_ctl;
        AddrPcr:  return out_ctl;
        AddrLer:  return 32'(latch_arm);
        AddrCtcr: return count_mode;
        default: begin
          slot = match_slot(addr);
          return (slot >= 0) ? match_reg[slot] : 32'd0;
        end
      endcase
    endfunction

    function void write_register(logic [AddrW-1:0] addr, logic [31:0] data);
      logic [CtrlW-1:0] old_ctrl;
      int slot;
      case (addr)
        AddrIr: irq_pending = irq_pending & ~data[FlagW-1:0] & IrqMask;
        AddrTcr: begin
          old_ctrl = ctrl;
          ctrl = data[CtrlW-1:0] & TcrMask;
          if (ctrl[TcrReset]) begin
            count = '0;
            prescale_cnt = '0;
          end else if (ctrl[TcrPwm] != old_ctrl[TcrPwm]) begin
            // Entering PWM mode restarts the count at one, leaving it at zero.
            count = ctrl[TcrPwm] ? 32'd1 : 32'd0;
            prescale_cnt = '0;
          end
        end
        AddrTc:   count = data;
        AddrPr:   prescale_max = data;
        AddrPc:   prescale_cnt = data;
        AddrMcr:  match_ctl = data;
        AddrPcr:  out_ctl = data;
        AddrLer:  latch_arm = data[LatchW-1:0] & LatchMask;
        AddrCtcr: count_mode = data;
        default: begin
          slot = match_slot(addr);
          if (slot >= 0) begin
            shadow_reg[slot] = data;
            if (!ctrl[TcrPwm]) match_reg[slot] = data;
          end
        end
      endcase
    endfunction

    function void advance_tick(output logic [EdgeW-1:0] edges, output logic start);
      logic reload;
      logic reload0;
      int i;
      edges = '0;
      start = 1'b0;
      reload = 1'b0;
      reload0 = 1'b0;
      if (!ctrl[TcrEnable] || ctrl[TcrReset]) return;
      // A prescale count above the limit behaves as if the limit was reached.
      if (prescale_cnt < prescale_max) begin
        prescale_cnt = prescale_cnt + 1;
        return;
      end
      prescale_cnt = '0;
      count = count + 1;
      for (i = 0; i < int'(NumMatch); i++) begin
        if (count == match_reg[i]) begin
          if (match_ctl[3*i]) irq_pending[(i <= 3) ? i : i + 4] = 1'b1;
          if (i >= 1 && out_ctl[8+i]) edges[i-1] = 1'b1;
          if (match_ctl[3*i+1]) begin
            reload = 1'b1;
            if (i == 0) reload0 = 1'b1;
          end
          if (match_ctl[3*i+2]) ctrl[TcrEnable] = 1'b0;
        end
      end
      if (reload) begin
        count = '0;
        prescale_cnt = '0;
        if (ctrl[TcrPwm]) begin
          for (i = 0; i < int'(NumMatch); i++)
            if (latch_arm[i]) match_reg[i] = shadow_reg[i];
          latch_arm = '0;
        end
        start = reload0;
      end
    endfunction

    function void note_access(logic [1:0] op, logic [AddrW-1:0] addr, logic [31:0] data);
      result_t res;
      logic [EdgeW-1:0] edges;
      logic start;
      res = '0;
      case (op)
        OpTick: begin
          advance_tick(edges, start);
          res.falling_edges = edges;
          res.cycle_start = start;
        end
        OpRead:  res.read_data = register_value(addr);
        OpWrite: write_register(addr, data);
        default: ;
      endcase
      res.irq_level = |irq_pending;
      expected_results.push_back(res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [31:0] rd, logic irq, logic [EdgeW-1:0] edges,
                               logic start);
      result_t want;
      if (expected_results.size() == 0) begin
        $error("result transfer with no access outstanding");
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("read_data", want.read_data, rd);
      compare_field("irq_level", 32'(want.irq_level), 32'(irq));
      compare_field("falling_edges", 32'(want.falling_edges), 32'(edges));
      compare_field("cycle_start", 32'(want.cycle_start), 32'(start));
      checked++;
      if (start) starts++;
      if (edges != '0) edge_hits++;
    endfunction
  endclass

  timer_scoreboard sb = new();

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(negedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(read_data_o, irq_level_o, falling_edges_o, cycle_start_o);
  end

  // Ends the run when no transfer happens on either side for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(negedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("tb NOT OK");
    $finish;
  end

  // Called at a rising edge; returns at the rising edge that takes the transfer.
  task automatic send_access(logic [1:0] op, logic [AddrW-1:0] addr, logic [31:0] data);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    address_i <= addr;
    write_data_i <= data;
    @(negedge clk_i);
    while (in_stall_o) @(negedge clk_i);
    sb.note_access(op, addr, data);
    items_sent++;
    @(posedge clk_i);
  endtask

  task automatic reg_write(logic [AddrW-1:0] addr, logic [31:0] data);
    send_access(OpWrite, addr, data);
  endtask

  task automatic reg_read(logic [AddrW-1:0] addr);
    send_access(OpRead, addr, $urandom());
  endtask

  function automatic logic [AddrW-1:0] reg_addr(int k);
    case (k)
      0:       return AddrIr;
      1:       return AddrTcr;
      2:       return AddrTc;
      3:       return AddrPr;
      4:       return AddrPc;
      5:       return AddrMcr;
      6:       return AddrMr0;
      7:       return AddrMr1;
      8:       return AddrMr2;
      9:       return AddrMr3;
      10:      return AddrMr4;
      11:      return AddrMr5;
      12:      return AddrMr6;
      13:      return AddrPcr;
      14:      return AddrLer;
      default: return AddrCtcr;
    endcase
  endfunction

  // Sets the timer up with small match values, then mostly ticks it with bus
  // traffic and some stray accesses mixed in.
  task automatic run_timer_burst();
    logic pwm;
    logic [31:0] mcr;
    int n;
    int k;
    int pick;
    pwm = 1'($urandom_range(1));
    if ($urandom_range(2) != 0) reg_write(AddrTcr, ($urandom() & ~32'hB) | 32'h2);
    reg_write(AddrPr, ($urandom_range(9) == 0) ? $urandom() : $urandom_range(2));
    if ($urandom_range(3) == 0) reg_write(AddrPc, $urandom_range(6));
    mcr = $urandom();
    if ($urandom_range(3) != 0) mcr = mcr & ~StopBits;
    if ($urandom_range(1) != 0) mcr[1] = 1'b1;
    reg_write(AddrMcr, mcr);
    reg_write(AddrPcr, $urandom());
    for (k = 0; k < int'(NumMatch); k++) begin
      if ($urandom_range(9) < 7)
        reg_write(reg_addr(6 + k), ($urandom_range(19) == 0) ? $urandom() : $urandom_range(12));
    end
    if (pwm) reg_write(AddrLer, $urandom());
    reg_write(AddrTcr, ($urandom() & ~32'hB) | 32'({pwm, 3'b001}));
    n = $urandom_range(10, 40);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 68) send_access(OpTick, 10'($urandom_range(1023)), $urandom());
      else if (pick < 80) reg_read(reg_addr($urandom_range(15)));
      else if (pick < 85) reg_write(AddrIr, $urandom());
      else if (pick < 89)
        reg_write(AddrTc, $urandom_range(1) ? $urandom_range(12)
                                            : 32'hFFFF_FFFF - $urandom_range(2));
      else if (pick < 94)
        reg_write(reg_addr(6 + $urandom_range(NumMatch - 1)), $urandom_range(12));
      else send_access(2'($urandom_range(3)), 10'($urandom_range(1023)), $urandom());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part: bus corner cases, prescale above limit, match flags,
    // wrap of the count, held reset and the PWM shadow latch.
    reg_write(AddrCtcr, 32'hFFFF_FFFF);
    reg_read(AddrCtcr);
    reg_write(AddrPr + 10'd1, 32'h1234_5678);
    reg_read(10'h3FF);
    send_access(OpUnused, AddrTc, 32'hFFFF_FFFF);
    reg_write(AddrPr, 32'd2);
    reg_write(AddrPc, 32'd5);
    reg_write(AddrMcr, 32'h0010_000B);
    reg_write(AddrMr0, 32'd3);
    reg_write(AddrMr1, 32'd1);
    reg_write(AddrPcr, 32'h0000_7E00);
    reg_write(AddrTcr, 32'h1);
    send_access(OpTick, 10'd0, 32'd0);
    reg_write(AddrPr, 32'd0);
    send_access(OpTick, 10'd0, 32'd0);
    send_access(OpTick, 10'd0, 32'd0);
    reg_write(AddrIr, 32'hFFFF_FFFF);
    reg_write(AddrTc, 32'hFFFF_FFFF);
    send_access(OpTick, 10'h3FF, 32'hFFFF_FFFF);
    reg_write(AddrTcr, 32'h3);
    reg_read(AddrTc);
    send_access(OpTick, 10'd0, 32'd0);
    reg_write(AddrTcr, 32'h9);
    reg_write(AddrMr0, 32'd2);
    reg_write(AddrLer, 32'hFFFF_FFFF);
    send_access(OpTick, 10'd0, 32'd0);
    send_access(OpTick, 10'd0, 32'd0);
    reg_read(AddrMr0);

    while (items_sent < 540) run_timer_burst();
    send_gap_pct = 63;
    stall_pct = 16;
    while (items_sent < 1070) run_timer_burst();
    send_gap_pct = 0;
    stall_pct = 0;
    while (items_sent < 1600) run_timer_burst();
    in_valid_i <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    $display("Sent %0d bus accesses and ticks under three idle/stall mixes.", items_sent);
    $display("Checked %0d results: %0d cycle starts, %0d with output edges.",
             sb.checked, sb.starts, sb.edge_hits);
    if (sb.errors == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
